// ===== rtl/ovnh_pkg.sv =====
// Shared types and constants for the octave value-noise height block.
// Used by the controller, the datapath and the top level.
package ovnh_pkg;

   // Configuration register indexes
   localparam logic [1:0] CSR_GRID_WIDTH      = 2'd0;
   localparam logic [1:0] CSR_GRID_DEPTH      = 2'd1;
   localparam logic [1:0] CSR_OCTAVE_COUNT    = 2'd2;
   localparam logic [1:0] CSR_BIAS_RECIPROCAL = 2'd3;

   localparam logic [7:0]  GRID_WIDTH_RST      = 8'd128;
   localparam logic [7:0]  GRID_DEPTH_RST      = 8'd128;
   localparam logic [3:0]  OCTAVE_COUNT_RST    = 4'd7;
   localparam logic [15:0] BIAS_RECIPROCAL_RST = 16'd29789;

   localparam logic [16:0] WEIGHT_ONE = 17'd65536;

   typedef struct packed {
      logic [7:0]  grid_width;
      logic [7:0]  grid_depth;
      logic [3:0]  octave_count;
      logic [15:0] bias_reciprocal;
   } cfg_type;

   // Datapath operations issued by the controller
   typedef enum logic [4:0] {
      OP_IDLE,
      OP_DIV_X,
      OP_WAIT,
      OP_DIV_Z,
      OP_CAP_Z,
      OP_OCT,
      OP_DIV_DX,
      OP_DIV_DZ,
      OP_CAP_DZ,
      OP_RD0,
      OP_RD1,
      OP_RD2,
      OP_RD3,
      OP_RD4,
      OP_MUL_A,
      OP_MUL_B,
      OP_DIV_V,
      OP_ACC,
      OP_DIV_H,
      OP_OUT
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic last_octave;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/ovnh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ovnh_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/ovnh_div.sv =====
// Restoring divider, one quotient bit per cycle, short mode for narrow operands.
// No dependencies.
module ovnh_div #(
   parameter int DW = 37,
   parameter int SB = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          short_op,
   input  logic [DW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic          busy,
   output logic [DW-1:0] quot,
   output logic [DW-1:0] rem
);

   localparam int CW = $clog2(DW + 1);

   logic [DW-1:0] quo_ff, rem_ff, dvs_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff;
   logic [DW:0]   trial;

   assign trial = {rem_ff, quo_ff[DW-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= short_op ? CW'(SB) : CW'(DW);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= short_op ? (dividend << (DW - SB)) : dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_ff <= DW'(trial - {1'b0, dvs_ff});
            quo_ff <= {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_ff <= trial[DW-1:0];
            quo_ff <= {quo_ff[DW-2:0], 1'b0};
         end
      end
   end

   assign busy = busy_ff;
   assign quot = quo_ff;
   assign rem  = rem_ff;

endmodule

// ===== rtl/ovnh_ctrl.sv =====
// Sequencer for height queries, walking the octave loop and the divisions; loads are taken while idle.
// Depends on ovnh_pkg.
module ovnh_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_action,
   output logic                   req_ready,
   input  ovnh_pkg::status_type   status,
   output ovnh_pkg::cmd_type      cmd
);
   import ovnh_pkg::*;

   typedef enum logic [26:0] {
      ST_IDLE    = 27'b1 << 0,
      ST_DIV_X   = 27'b1 << 1,
      ST_WAIT_X  = 27'b1 << 2,
      ST_DIV_Z   = 27'b1 << 3,
      ST_WAIT_Z  = 27'b1 << 4,
      ST_CAP_Z   = 27'b1 << 5,
      ST_OCT     = 27'b1 << 6,
      ST_DIV_DX  = 27'b1 << 7,
      ST_WAIT_DX = 27'b1 << 8,
      ST_DIV_DZ  = 27'b1 << 9,
      ST_WAIT_DZ = 27'b1 << 10,
      ST_CAP_DZ  = 27'b1 << 11,
      ST_RD0     = 27'b1 << 12,
      ST_RD1     = 27'b1 << 13,
      ST_RD2     = 27'b1 << 14,
      ST_RD3     = 27'b1 << 15,
      ST_RD4     = 27'b1 << 16,
      ST_MUL_A   = 27'b1 << 17,
      ST_MUL_B   = 27'b1 << 18,
      ST_DIV_V   = 27'b1 << 19,
      ST_WAIT_V  = 27'b1 << 20,
      ST_ACC     = 27'b1 << 21,
      ST_DIV_H   = 27'b1 << 22,
      ST_WAIT_H  = 27'b1 << 23,
      ST_OUT     = 27'b1 << 24,
      ST_SPARE0  = 27'b1 << 25,
      ST_SPARE1  = 27'b1 << 26
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_valid && req_action) state_in = ST_DIV_X;
         ST_DIV_X:   state_in = ST_WAIT_X;
         ST_WAIT_X:  if (!status.div_busy) state_in = ST_DIV_Z;
         ST_DIV_Z:   state_in = ST_WAIT_Z;
         ST_WAIT_Z:  if (!status.div_busy) state_in = ST_CAP_Z;
         ST_CAP_Z:   state_in = ST_OCT;
         ST_OCT:     state_in = ST_DIV_DX;
         ST_DIV_DX:  state_in = ST_WAIT_DX;
         ST_WAIT_DX: if (!status.div_busy) state_in = ST_DIV_DZ;
         ST_DIV_DZ:  state_in = ST_WAIT_DZ;
         ST_WAIT_DZ: if (!status.div_busy) state_in = ST_CAP_DZ;
         ST_CAP_DZ:  state_in = ST_RD0;
         ST_RD0:     state_in = ST_RD1;
         ST_RD1:     state_in = ST_RD2;
         ST_RD2:     state_in = ST_RD3;
         ST_RD3:     state_in = ST_RD4;
         ST_RD4:     state_in = ST_MUL_A;
         ST_MUL_A:   state_in = ST_MUL_B;
         ST_MUL_B:   state_in = ST_DIV_V;
         ST_DIV_V:   state_in = ST_WAIT_V;
         ST_WAIT_V:  if (!status.div_busy) state_in = ST_ACC;
         ST_ACC:     state_in = status.last_octave ? ST_DIV_H : ST_OCT;
         ST_DIV_H:   state_in = ST_WAIT_H;
         ST_WAIT_H:  if (!status.div_busy) state_in = ST_OUT;
         ST_OUT:     if (status.out_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      unique case (state_ff)
         ST_IDLE:   cmd.op = OP_IDLE;
         ST_DIV_X:  cmd.op = OP_DIV_X;
         ST_DIV_Z:  cmd.op = OP_DIV_Z;
         ST_CAP_Z:  cmd.op = OP_CAP_Z;
         ST_OCT:    cmd.op = OP_OCT;
         ST_DIV_DX: cmd.op = OP_DIV_DX;
         ST_DIV_DZ: cmd.op = OP_DIV_DZ;
         ST_CAP_DZ: cmd.op = OP_CAP_DZ;
         ST_RD0:    cmd.op = OP_RD0;
         ST_RD1:    cmd.op = OP_RD1;
         ST_RD2:    cmd.op = OP_RD2;
         ST_RD3:    cmd.op = OP_RD3;
         ST_RD4:    cmd.op = OP_RD4;
         ST_MUL_A:  cmd.op = OP_MUL_A;
         ST_MUL_B:  cmd.op = OP_MUL_B;
         ST_DIV_V:  cmd.op = OP_DIV_V;
         ST_ACC:    cmd.op = OP_ACC;
         ST_DIV_H:  cmd.op = OP_DIV_H;
         ST_OUT:    cmd.op = OP_OUT;
         default:   cmd.op = OP_WAIT;
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule

// ===== rtl/ovnh_dp.sv =====
// Datapath: seed store, shared divider, bilinear blend, octave accumulation.
// Depends on ovnh_pkg, ovnh_ram and ovnh_div.
module ovnh_dp #(
   parameter int MAX_DIM   = 128,
   parameter int SEED_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ovnh_pkg::cfg_type    cfg,
   input  ovnh_pkg::cmd_type    cmd,
   output ovnh_pkg::status_type status,
   input  logic                 req_valid,
   input  logic                 req_action,
   input  logic [6:0]           req_col,
   input  logic [6:0]           req_row,
   input  logic [15:0]          req_seed_value,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [15:0]          rsp_height,
   output logic [6:0]           rsp_out_col,
   output logic [6:0]           rsp_out_row
);
   import ovnh_pkg::*;

   localparam int S    = SEED_BITS;
   localparam int DB   = $clog2(MAX_DIM + 1);
   localparam int SB   = (DB > 7) ? DB : 7;
   localparam int AW   = $clog2(MAX_DIM * MAX_DIM);
   localparam int TW   = DB + S;
   localparam int NW   = 2 * DB + S;
   localparam int ACW  = S + 20;
   localparam int WSW  = 20;
   localparam int DW   = ((NW + 1) > (ACW + 1)) ? (NW + 1) : (ACW + 1);
   localparam int RSH  = (S >= 16) ? (S - 16) : 0;
   localparam int LSH  = (S < 16) ? (16 - S) : 0;
   localparam logic [AW-1:0] DIM_A = AW'(MAX_DIM);

   logic [6:0]      col_ff, row_ff;
   logic [DB-1:0]   w_ff, d_ff, x_ff, z_ff, px_ff, pz_ff;
   logic [DB-1:0]   dx_ff, dz_ff, x1_ff, x2_ff, z1_ff, z2_ff;
   logic [3:0]      n_ff;
   logic [2:0]      oct_ff;
   logic [S-1:0]    s_ff [4];
   logic [TW-1:0]   top_ff, bot_ff;
   logic [2*DB-1:0] den_ff;
   logic [NW-1:0]   num_ff;
   logic [ACW-1:0]  acc_ff;
   logic [WSW-1:0]  wsum_ff;
   logic [16:0]     wt_ff;
   logic            rsp_valid_ff;
   logic [15:0]     height_ff;
   logic [6:0]      out_col_ff, out_row_ff;

   logic            accept, query, load;
   logic            div_start, div_short, div_busy;
   logic [DW-1:0]   div_a, div_b, div_q, div_r;
   logic [DB-1:0]   rem_n, x1_n, z1_n, px_n, pz_n;
   logic [DB:0]     x2_s, z2_s;
   logic [DB-1:0]   w_n, d_n;
   logic [3:0]      n_n;
   logic [AW-1:0]   rd_addr, wr_addr;
   logic [S-1:0]    rd_data;
   logic            out_free;
   logic [S+16:0]   h_x;

   assign accept = (cmd.op == OP_IDLE) && req_valid;
   assign query  = accept && req_action;
   assign load   = accept && !req_action
                   && (SB'(req_col) < SB'(MAX_DIM)) && (SB'(req_row) < SB'(MAX_DIM));

   // Clamp the grid size and octave count
   always_comb begin
      if (cfg.grid_width < 8'd2)               w_n = DB'(2);
      else if (32'(cfg.grid_width) > MAX_DIM)  w_n = DB'(MAX_DIM);
      else                                     w_n = DB'(cfg.grid_width);
      if (cfg.grid_depth < 8'd2)               d_n = DB'(2);
      else if (32'(cfg.grid_depth) > MAX_DIM)  d_n = DB'(MAX_DIM);
      else                                     d_n = DB'(cfg.grid_depth);
      if (cfg.octave_count == 4'd0)            n_n = 4'd1;
      else if (cfg.octave_count > 4'd8)        n_n = 4'd8;
      else                                     n_n = cfg.octave_count;
   end

   // Divider operand selection
   always_comb begin
      div_start = 1'b1;
      div_short = 1'b1;
      div_a     = '0;
      div_b     = DW'(1);
      case (cmd.op)
         OP_DIV_X: begin
            div_a = DW'(col_ff);
            div_b = DW'(w_ff);
         end
         OP_DIV_Z: begin
            div_a = DW'(row_ff);
            div_b = DW'(d_ff);
         end
         OP_DIV_DX: begin
            div_a = DW'(x_ff);
            div_b = DW'(px_ff);
         end
         OP_DIV_DZ: begin
            div_a = DW'(z_ff);
            div_b = DW'(pz_ff);
         end
         OP_DIV_V: begin
            div_short = 1'b0;
            div_a     = DW'(num_ff) + DW'(den_ff >> 1);
            div_b     = DW'(den_ff);
         end
         OP_DIV_H: begin
            div_short = 1'b0;
            div_a     = DW'(acc_ff) + DW'(wsum_ff >> 1);
            div_b     = DW'(wsum_ff);
         end
         default: div_start = 1'b0;
      endcase
   end

   ovnh_div #(.DW(DW), .SB(SB)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .short_op (div_short),
      .dividend (div_a),
      .divisor  (div_b),
      .busy     (div_busy),
      .quot     (div_q),
      .rem      (div_r)
   );

   assign rem_n = DB'(div_r);
   assign x1_n  = x_ff - rem_n;
   assign z1_n  = z_ff - rem_n;
   assign x2_s  = (DB+1)'(x1_n) + (DB+1)'(px_ff);
   assign z2_s  = (DB+1)'(z1_n) + (DB+1)'(pz_ff);
   assign px_n  = w_ff >> oct_ff;
   assign pz_n  = d_ff >> oct_ff;

   // Seed store addressing
   always_comb begin
      case (cmd.op)
         OP_RD0:  rd_addr = AW'(AW'(z1_ff) * DIM_A + AW'(x1_ff));
         OP_RD1:  rd_addr = AW'(AW'(z1_ff) * DIM_A + AW'(x2_ff));
         OP_RD2:  rd_addr = AW'(AW'(z2_ff) * DIM_A + AW'(x1_ff));
         default: rd_addr = AW'(AW'(z2_ff) * DIM_A + AW'(x2_ff));
      endcase
   end

   assign wr_addr = AW'(AW'(req_row) * DIM_A + AW'(req_col));

   ovnh_ram #(.WIDTH(S), .DEPTH(MAX_DIM * MAX_DIM)) u_seed_ram (
      .clock   (clock),
      .wr_en   (load),
      .wr_addr (wr_addr),
      .wr_data (S'(req_seed_value)),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (query) begin
         col_ff  <= req_col;
         row_ff  <= req_row;
         w_ff    <= w_n;
         d_ff    <= d_n;
         n_ff    <= n_n;
         oct_ff  <= '0;
         acc_ff  <= '0;
         wsum_ff <= '0;
         wt_ff   <= WEIGHT_ONE;
      end
      case (cmd.op)
         OP_DIV_Z: x_ff <= rem_n;
         OP_CAP_Z: z_ff <= rem_n;
         OP_OCT: begin
            px_ff <= (px_n == '0) ? DB'(1) : px_n;
            pz_ff <= (pz_n == '0) ? DB'(1) : pz_n;
         end
         OP_DIV_DZ: begin
            dx_ff <= rem_n;
            x1_ff <= x1_n;
            x2_ff <= (x2_s >= (DB+1)'(w_ff)) ? DB'(x2_s - (DB+1)'(w_ff)) : DB'(x2_s);
         end
         OP_CAP_DZ: begin
            dz_ff <= rem_n;
            z1_ff <= z1_n;
            z2_ff <= (z2_s >= (DB+1)'(d_ff)) ? DB'(z2_s - (DB+1)'(d_ff)) : DB'(z2_s);
         end
         OP_RD1: s_ff[0] <= rd_data;
         OP_RD2: s_ff[1] <= rd_data;
         OP_RD3: s_ff[2] <= rd_data;
         OP_RD4: s_ff[3] <= rd_data;
         OP_MUL_A: begin
            top_ff <= TW'(TW'(px_ff - dx_ff) * TW'(s_ff[0]) + TW'(dx_ff) * TW'(s_ff[1]));
            bot_ff <= TW'(TW'(px_ff - dx_ff) * TW'(s_ff[2]) + TW'(dx_ff) * TW'(s_ff[3]));
            den_ff <= (2*DB)'((2*DB)'(px_ff) * (2*DB)'(pz_ff));
         end
         OP_MUL_B: begin
            num_ff <= NW'(NW'(pz_ff - dz_ff) * NW'(top_ff) + NW'(dz_ff) * NW'(bot_ff));
         end
         OP_ACC: begin
            acc_ff  <= acc_ff + ACW'(ACW'(S'(div_q)) * ACW'(wt_ff));
            wsum_ff <= wsum_ff + WSW'(wt_ff);
            wt_ff   <= 17'((33'(wt_ff) * 33'(cfg.bias_reciprocal) + 33'd32768) >> 16);
            oct_ff  <= oct_ff + 3'd1;
         end
         default: ;
      endcase
   end

   // Result register
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign h_x      = ((S+17)'(div_q) >> RSH) << LSH;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((cmd.op == OP_OUT) && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((cmd.op == OP_OUT) && out_free) begin
         height_ff  <= (h_x > (S+17)'(65535)) ? 16'hFFFF : h_x[15:0];
         out_col_ff <= col_ff;
         out_row_ff <= row_ff;
      end
   end

   assign status.div_busy    = div_busy;
   assign status.last_octave = ((4'(oct_ff) + 4'd1) == n_ff);
   assign status.out_free    = out_free;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_height  = height_ff;
   assign rsp_out_col = out_col_ff;
   assign rsp_out_row = out_row_ff;

endmodule

// ===== rtl/octave_value_noise_height.sv =====
// Top level of the octave value-noise height block: configuration registers,
// controller and datapath. Depends on ovnh_pkg, ovnh_ctrl and ovnh_dp.
//
// A load transaction (action 0) writes one seed into the grid store in the
// cycle it is accepted and produces no result; an entry must be loaded before
// a query reads it. A query transaction (action 1) returns one result with the
// normalized height and the echoed col and row. Queries run one at a time: the
// input side is ready again only after the result has moved into the output
// register, which may still hold the previous result while the next query is
// under way. A finished result waits until the output register frees up. The
// single shared one-bit-per-cycle divider takes all modulo steps, every
// octave's blend normalization and the final weighted average; the narrow
// divisions are SB bits wide (8 at the default size) and the wide ones DW
// bits (37 at the default size). The seed store has a single read port, so
// each octave reads its four corner seeds one after another.
// The user must write the configuration port only while no query is in
// flight; the block itself does not enforce this.
module octave_value_noise_height #(
   parameter int MAX_DIM   = 128,
   parameter int SEED_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [6:0]  req_col,
   input  logic [6:0]  req_row,
   input  logic [15:0] req_seed_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_height,
   output logic [6:0]  rsp_out_col,
   output logic [6:0]  rsp_out_row,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wr_data
);
   import ovnh_pkg::*;

   cfg_type    cfg_ff;
   cmd_type    cmd;
   status_type status;

   // Decode configuration writes; hold values otherwise
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_width      <= GRID_WIDTH_RST;
         cfg_ff.grid_depth      <= GRID_DEPTH_RST;
         cfg_ff.octave_count    <= OCTAVE_COUNT_RST;
         cfg_ff.bias_reciprocal <= BIAS_RECIPROCAL_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_GRID_WIDTH:      cfg_ff.grid_width      <= csr_wr_data[7:0];
            CSR_GRID_DEPTH:      cfg_ff.grid_depth      <= csr_wr_data[7:0];
            CSR_OCTAVE_COUNT:    cfg_ff.octave_count    <= csr_wr_data[3:0];
            CSR_BIAS_RECIPROCAL: cfg_ff.bias_reciprocal <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // Sequence each query through the octave loop
   ovnh_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_ready  (req_ready),
      .status     (status),
      .cmd        (cmd)
   );

   // Seed store, divider and blend arithmetic
   ovnh_dp #(
      .MAX_DIM   (MAX_DIM),
      .SEED_BITS (SEED_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .cmd            (cmd),
      .status         (status),
      .req_valid      (req_valid),
      .req_action     (req_action),
      .req_col        (req_col),
      .req_row        (req_row),
      .req_seed_value (req_seed_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_height     (rsp_height),
      .rsp_out_col    (rsp_out_col),
      .rsp_out_row    (rsp_out_row)
   );

endmodule

// ===== tb/octave_value_noise_height_tb.sv =====
// Testbench for octave_value_noise_height: directed and random load/query traffic,
// register phases and a scoreboard with its own height predictor. Depends on ovnh_pkg.
// Self-checking, standalone; needs only the RTL.
module octave_value_noise_height_tb;
   import ovnh_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int GRID_ENTRIES = 128 * 128;
   localparam int STALL_LIMIT  = 20000;
   localparam int HOLD_CYCLES  = 3000;

   // Scoreboard: mirrors the seed grid and the registers, predicts each height
   // and checks the results in order.
   class height_board;
      typedef struct {
         logic [15:0] height;
         logic [6:0]  col;
         logic [6:0]  row;
      } height_result_type;

      logic [15:0]       seeds[GRID_ENTRIES];
      bit                planned[GRID_ENTRIES];
      logic [7:0]        grid_width;
      logic [7:0]        grid_depth;
      logic [3:0]        octave_count;
      logic [15:0]       bias_reciprocal;
      height_result_type awaited[$];
      int                fails;
      int                loads;
      int                queries;

      function new();
         grid_width      = GRID_WIDTH_RST;
         grid_depth      = GRID_DEPTH_RST;
         octave_count    = OCTAVE_COUNT_RST;
         bias_reciprocal = BIAS_RECIPROCAL_RST;
         fails = 0;
         loads = 0;
         queries = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [15:0] value);
         case (idx)
            CSR_GRID_WIDTH:      grid_width      = value[7:0];
            CSR_GRID_DEPTH:      grid_depth      = value[7:0];
            CSR_OCTAVE_COUNT:    octave_count    = value[3:0];
            CSR_BIAS_RECIPROCAL: bias_reciprocal = value;
            default: ;
         endcase
      endfunction

      function int unsigned clamp_dim(int unsigned v);
         if (v < 2) return 2;
         if (v > 128) return 128;
         return v;
      endfunction

      function int unsigned octaves();
         if (octave_count < 1) return 1;
         if (octave_count > 8) return 8;
         return octave_count;
      endfunction

      // Cell corners and offsets of the point inside octave i.
      function void corners(int unsigned i, int unsigned col, int unsigned row,
                            output int unsigned x1, output int unsigned z1,
                            output int unsigned x2, output int unsigned z2,
                            output int unsigned dx, output int unsigned dz,
                            output int unsigned px, output int unsigned pz);
         int unsigned w, d, x, z;
         w  = clamp_dim(grid_width);
         d  = clamp_dim(grid_depth);
         x  = col % w;
         z  = row % d;
         px = w >> i;
         pz = d >> i;
         if (px < 1) px = 1;
         if (pz < 1) pz = 1;
         x1 = (x / px) * px;
         z1 = (z / pz) * pz;
         x2 = (x1 + px) % w;
         z2 = (z1 + pz) % d;
         dx = x - x1;
         dz = z - z1;
      endfunction

      // Collect grid entries a query would read that no load has covered yet.
      function void missing(int unsigned col, int unsigned row, ref int unsigned addrs[$]);
         int unsigned x1, z1, x2, z2, dx, dz, px, pz;
         int unsigned a[4];
         for (int unsigned i = 0; i < octaves(); i++) begin
            corners(i, col, row, x1, z1, x2, z2, dx, dz, px, pz);
            a[0] = z1 * 128 + x1;
            a[1] = z1 * 128 + x2;
            a[2] = z2 * 128 + x1;
            a[3] = z2 * 128 + x2;
            foreach (a[k]) begin
               if (!planned[a[k]]) begin
                  planned[a[k]] = 1'b1;
                  addrs.push_back(a[k]);
               end
            end
         end
      endfunction

      function logic [15:0] height_at(int unsigned col, int unsigned row);
         int unsigned x1, z1, x2, z2, dx, dz, px, pz;
         longint unsigned weight, acc, wsum, top, bot, num, den, val, h;
         weight = 65536;
         acc = 0;
         wsum = 0;
         for (int unsigned i = 0; i < octaves(); i++) begin
            corners(i, col, row, x1, z1, x2, z2, dx, dz, px, pz);
            top = longint'(px - dx) * seeds[z1 * 128 + x1] + longint'(dx) * seeds[z1 * 128 + x2];
            bot = longint'(px - dx) * seeds[z2 * 128 + x1] + longint'(dx) * seeds[z2 * 128 + x2];
            num = longint'(pz - dz) * top + longint'(dz) * bot;
            den = longint'(px) * pz;
            val = (num + den / 2) / den;
            acc += val * weight;
            wsum += weight;
            weight = (weight * bias_reciprocal + 32768) >> 16;
         end
         h = (acc + wsum / 2) / wsum;
         if (h > 65535) h = 65535;
         return h[15:0];
      endfunction

      function void note_input(logic action, logic [6:0] col, logic [6:0] row,
                               logic [15:0] seed);
         height_result_type res;
         if (!action) begin
            seeds[row * 128 + col] = seed;
            planned[row * 128 + col] = 1'b1;
            loads++;
         end else begin
            res.height = height_at(col, row);
            res.col = col;
            res.row = row;
            awaited.push_back(res);
            queries++;
         end
      endfunction

      function void check(logic [15:0] height, logic [6:0] col, logic [6:0] row);
         height_result_type exp_res;
         if (awaited.size() == 0) begin
            $display("%0t: unexpected result height=%0d col=%0d row=%0d",
                     $realtime, height, col, row);
            fails++;
            return;
         end
         exp_res = awaited.pop_front();
         if (height !== exp_res.height) begin
            $display("%0t: height mismatch expected %0d actual %0d", $realtime,
                     exp_res.height, height);
            fails++;
         end
         if (col !== exp_res.col) begin
            $display("%0t: out_col mismatch expected %0d actual %0d", $realtime,
                     exp_res.col, col);
            fails++;
         end
         if (row !== exp_res.row) begin
            $display("%0t: out_row mismatch expected %0d actual %0d", $realtime,
                     exp_res.row, row);
            fails++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_action;
   logic [6:0]  req_col;
   logic [6:0]  req_row;
   logic [15:0] req_seed_value;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [15:0] rsp_height;
   logic [6:0]  rsp_out_col;
   logic [6:0]  rsp_out_row;
   logic        csr_wr_en;
   logic [1:0]  csr_index;
   logic [15:0] csr_wr_data;

   height_board board;
   bit          steady;     // no idling on either side while set
   bit          hold_rsp;   // ask the receiver for one long hold-off
   int          idle_cycles;
   int          phases;

   octave_value_noise_height u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_col        (req_col),
      .req_row        (req_row),
      .req_seed_value (req_seed_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_height     (rsp_height),
      .rsp_out_col    (rsp_out_col),
      .rsp_out_row    (rsp_out_row),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Receiver: drop ready with a chance of about 23 percent, except in steady
   // stretches; once, hold it low for a long stretch so the block backs up.
   initial begin
      int hold_count;
      hold_count = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp && hold_count == 0) begin
            hold_count = HOLD_CYCLES;
            hold_rsp = 1'b0;
         end
         if (hold_count > 0) begin
            hold_count--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= steady || ($urandom_range(99) >= 23);
         end
      end
   end

   // Check every result transaction against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check(rsp_height, rsp_out_col, rsp_out_row);
   end

   // Watchdog: count cycles in which neither channel moves a transaction.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $realtime, STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // Offer one input transaction, sometimes after a random gap, and hold it until taken.
   task automatic send(logic action, int unsigned col, int unsigned row, logic [15:0] seed);
      int gap;
      gap = (!steady && $urandom_range(99) < 23) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= action;
      req_col        <= col[6:0];
      req_row        <= row[6:0];
      req_seed_value <= seed;
      do @(posedge clock); while (!req_ready);
      board.note_input(action, col[6:0], row[6:0], seed);
   endtask

   function automatic logic [15:0] pick_seed();
      case ($urandom_range(7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom_range(16'hFFFF));
      endcase
   endfunction

   // Load whatever the query still needs, then issue the query itself.
   task automatic query(int unsigned col, int unsigned row);
      int unsigned addrs[$];
      board.missing(col, row, addrs);
      foreach (addrs[k])
         send(1'b0, addrs[k] % 128, addrs[k] / 128, pick_seed());
      send(1'b1, col, row, 16'($urandom_range(16'hFFFF)));
   endtask

   task automatic load(int unsigned col, int unsigned row, logic [15:0] seed);
      send(1'b0, col, row, seed);
   endtask

   // Wait for every predicted result, then let the block settle before a register write.
   task automatic drain();
      req_valid <= 1'b0;
      while (board.awaited.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Present one register write for one edge; the caller drops the enable.
   task automatic write_reg(logic [1:0] idx, logic [15:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(posedge clock);
      board.set_reg(idx, value);
   endtask

   task automatic set_phase(logic [7:0] w, logic [7:0] d, logic [3:0] n, logic [15:0] b);
      drain();
      write_reg(CSR_GRID_WIDTH, {8'd0, w});
      write_reg(CSR_GRID_DEPTH, {8'd0, d});
      write_reg(CSR_OCTAVE_COUNT, {12'd0, n});
      write_reg(CSR_BIAS_RECIPROCAL, b);
      csr_wr_en <= 1'b0;
      phases++;
   endtask

   // Random traffic: mostly queries with their loads, some stray loads.
   task automatic random_traffic(int count);
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(99) < 70)
            query($urandom_range(127), $urandom_range(127));
         else
            load($urandom_range(127), $urandom_range(127), pick_seed());
      end
   endtask

   initial begin
      board          = new();
      steady         = 1'b0;
      hold_rsp       = 1'b0;
      phases         = 1;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_action     = 1'b0;
      req_col        = '0;
      req_row        = '0;
      req_seed_value = '0;
      csr_wr_en      = 1'b0;
      csr_index      = CSR_GRID_WIDTH;
      csr_wr_data    = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extreme seeds and corners at the reset settings.
      load(0, 0, 16'h0000);
      load(127, 127, 16'hFFFF);
      load(127, 0, 16'hFFFF);
      query(0, 0);
      query(127, 127);
      query(64, 63);

      // Tiny grid, all octaves, zero bias: pitch drops to one and wraps.
      set_phase(8'd5, 8'd3, 4'd8, 16'd0);
      query(127, 127);
      query(4, 2);
      query(0, 0);

      // All-ones 2x2 grid drives the height to full scale; octave count
      // above the limit is clamped.
      set_phase(8'd2, 8'd2, 4'd15, 16'hFFFF);
      load(0, 0, 16'hFFFF);
      load(1, 0, 16'hFFFF);
      load(0, 1, 16'hFFFF);
      load(1, 1, 16'hFFFF);
      query(1, 1);
      query(126, 127);

      // Out-of-range sizes and zero octaves are clamped.
      set_phase(8'd255, 8'd1, 4'd0, 16'd1);
      query(127, 5);
      query(3, 126);
      random_traffic(60);

      // Full grid, eight octaves; hold the receiver off while input continues.
      set_phase(8'd128, 8'd128, 4'd8, 16'hFFFF);
      hold_rsp = 1'b1;
      random_traffic(40);

      // Steady stretch with no idling on either side.
      set_phase(8'd64, 8'd100, 4'd3, 16'h8000);
      steady = 1'b1;
      random_traffic(120);
      steady = 1'b0;

      // Random register settings, legal and clamped alike, small sizes favored.
      for (int p = 0; p < 8; p++) begin
         set_phase(8'((p % 3 == 0) ? $urandom_range(255) : $urandom_range(2, 32)),
                   8'((p % 3 == 1) ? $urandom_range(255) : $urandom_range(2, 32)),
                   4'($urandom_range(15)), 16'($urandom_range(16'hFFFF)));
         random_traffic(16);
      end

      drain();
      $display("Covered %0d loads and %0d queries over %0d register settings,",
               board.loads, board.queries, phases);
      $display("including clamped sizes, wrapped points, zero bias and a long output stall.");
      if (board.fails == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== octave_value_noise_height.f =====
rtl/ovnh_pkg.sv
rtl/ovnh_ram.sv
rtl/ovnh_div.sv
rtl/ovnh_ctrl.sv
rtl/ovnh_dp.sv
rtl/octave_value_noise_height.sv
tb/octave_value_noise_height_tb.sv
